>>> src/multi_led_blink_controller_assert.svh
// Assertion macros for the LED blink controller.
// The bodies expand to concurrent assertions clocked on clk and disabled in reset.
`ifndef MULTI_LED_BLINK_CONTROLLER_ASSERT_SVH
`define MULTI_LED_BLINK_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define MLBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MLBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MLBC_ASSERT_IMP(lbl, ante, cons, msg)
`define MLBC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/mlbc_pkg.sv
package mlbc_pkg;

    // Channel count and the number of channels that the 3-bit index can reach.
    localparam int LED_CHANNELS = 8;
    localparam int SCAN_CH      = (LED_CHANNELS < 8) ? LED_CHANNELS : 8;
    localparam int LED_W        = 3;

    // Stream widths, padded to whole bytes.
    localparam int IN_TDATA_W   = 80;
    localparam int OUT_TDATA_W  = 16;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_SET_MODE   = 2'd1;
    localparam logic [1:0] OP_SET_STEADY = 2'd2;

    // Channel modes.
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;

    // Inverted drive levels.
    localparam logic [7:0] LEVEL_DARK = 8'hFF;
    localparam logic [7:0] LEVEL_LIT  = 8'h00;

    typedef logic [LED_W-1:0] led_t;

    // One input item as held during its scan.
    typedef struct packed {
        logic [1:0]  op;
        led_t        target_led;
        logic [1:0]  mode;
        logic [7:0]  duty;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic [31:0] now_ms;
        logic        driver_ready;
    } item_t;

    // Write request handed along the cell row.
    typedef struct packed {
        logic       emit;
        led_t       led;
        logic [7:0] level;
    } res_t;

endpackage

>>> src/mlbc_cell.sv
module mlbc_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  mlbc_pkg::led_t  cell_idx,
    input  logic            shift,
    input  logic            tok_in,
    output logic            tok_out,
    input  mlbc_pkg::item_t item,
    input  mlbc_pkg::res_t  res_in,
    output mlbc_pkg::res_t  res_out
);
    import mlbc_pkg::*;

    logic        tok_reg;
    logic [1:0]  mode_reg,   mode_next;
    logic [7:0]  duty_reg,   duty_next;
    logic [15:0] on_reg,     on_next;
    logic [15:0] off_reg,    off_next;
    logic [31:0] stamp_reg,  stamp_next;
    logic        lit_reg,    lit_next;
    logic        pend_reg,   pend_next;

    logic        commit;
    logic        match;
    logic        tick;
    logic [15:0] on_eff;
    logic [15:0] off_eff;
    logic [15:0] interval;
    logic [31:0] elapsed;
    res_t        own_res;

    assign commit = tok_reg && shift;
    assign match  = (item.target_led == cell_idx);
    assign tick   = (item.op == OP_TICK) && item.driver_ready;

    // Blink interval of the current phase; a zero time counts as one.
    assign on_eff   = (on_reg == 16'd0) ? 16'd1 : on_reg;
    assign off_eff  = (off_reg == 16'd0) ? 16'd1 : off_reg;
    assign interval = lit_reg ? on_eff : off_eff;
    assign elapsed  = item.now_ms - stamp_reg;

    // Channel update and write request for the item passing through.
    always_comb
    begin
        mode_next   = mode_reg;
        duty_next   = duty_reg;
        on_next     = on_reg;
        off_next    = off_reg;
        stamp_next  = stamp_reg;
        lit_next    = lit_reg;
        pend_next   = pend_reg;
        own_res     = '0;
        own_res.led = cell_idx;
        priority if (tick)
        begin
            unique case (mode_reg)
                MODE_OFF:
                begin
                    own_res.emit  = 1'b1;
                    own_res.level = LEVEL_DARK;
                    stamp_next    = item.now_ms;
                    lit_next      = 1'b0;
                end
                MODE_ON:
                begin
                    own_res.emit  = 1'b1;
                    own_res.level = LEVEL_DARK - duty_reg;
                    stamp_next    = item.now_ms;
                    lit_next      = 1'b1;
                end
                MODE_BLINK:
                begin
                    if (pend_reg)
                    begin
                        lit_next      = 1'b1;
                        pend_next     = 1'b0;
                        stamp_next    = item.now_ms;
                        own_res.emit  = 1'b1;
                        own_res.level = LEVEL_LIT;
                    end
                    else if (elapsed >= {16'd0, interval})
                    begin
                        lit_next      = !lit_reg;
                        stamp_next    = item.now_ms;
                        own_res.emit  = 1'b1;
                        own_res.level = lit_reg ? LEVEL_DARK : LEVEL_LIT;
                    end
                end
                default:
                begin
                    own_res.emit = 1'b0;
                end
            endcase
        end
        else if ((item.op == OP_SET_MODE) && match)
        begin
            if (item.mode == MODE_BLINK)
            begin
                mode_next = MODE_BLINK;
                on_next   = item.on_ms;
                off_next  = item.off_ms;
                duty_next = LEVEL_DARK;
                pend_next = 1'b1;
            end
            else if ((item.mode == MODE_OFF) || (item.mode == MODE_ON))
            begin
                mode_next  = item.mode;
                on_next    = 16'd0;
                off_next   = 16'd0;
                stamp_next = item.now_ms;
                duty_next  = (item.mode == MODE_ON) ? LEVEL_DARK : 8'd0;
                pend_next  = 1'b0;
            end
        end
        else if ((item.op == OP_SET_STEADY) && match)
        begin
            mode_next     = (item.duty == 8'd0) ? MODE_OFF : MODE_ON;
            duty_next     = item.duty;
            on_next       = 16'd0;
            off_next      = 16'd0;
            stamp_next    = item.now_ms;
            pend_next     = 1'b0;
            own_res.emit  = item.driver_ready;
            own_res.level = LEVEL_DARK - item.duty;
        end
        else
        begin
            own_res.emit = 1'b0;
        end
    end

    // The active cell places its request on the chain, others pass it on.
    assign res_out = tok_reg ? own_res : res_in;
    assign tok_out = tok_reg;

    // Token shift and channel state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= 1'b0;
            mode_reg  <= MODE_OFF;
            duty_reg  <= 8'd0;
            on_reg    <= 16'd0;
            off_reg   <= 16'd0;
            stamp_reg <= 32'd0;
            lit_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (shift)
            begin
                tok_reg <= tok_in;
            end
            if (commit)
            begin
                mode_reg  <= mode_next;
                duty_reg  <= duty_next;
                on_reg    <= on_next;
                off_reg   <= off_next;
                stamp_reg <= stamp_next;
                lit_reg   <= lit_next;
                pend_reg  <= pend_next;
            end
        end
    end

endmodule

>>> src/multi_led_blink_controller.sv
// Each item passes a token down a row of channel cells, one cell per cycle while the output
// is free, then releases its final write before the next item can be accepted.
// A write waits in a one-deep buffer until the next write of its item or the scan end.
// Output stalls hold the token.
// rst_n clears all channel state to off and empties the token row and buffers.
`include "multi_led_blink_controller_assert.svh"

module multi_led_blink_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // target_led[2:0], mode[4:3], duty[12:5], on_ms[28:13], off_ms[44:29],
    // now_ms[76:45], driver_ready[77], zero pad[79:78]
    input  logic [mlbc_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // driven_led[2:0], drive_level[10:3], zero pad[15:11]
    output logic [mlbc_pkg::OUT_TDATA_W-1:0] m_tdata,
    // last_write
    output logic                             m_tlast
);
    import mlbc_pkg::*;

    item_t        item_reg;
    logic         busy_reg;
    logic         flush_reg;
    logic         held_valid_reg;
    led_t         held_led_reg;
    logic [7:0]   held_level_reg;
    logic         m_tvalid_reg;
    led_t         m_led_reg;
    logic [7:0]   m_level_reg;
    logic         m_tlast_reg;

    logic               start;
    logic               out_ok;
    logic               adv;
    logic               shift;
    logic               scan_end;
    logic [SCAN_CH-1:0] tok_vec;
    logic [SCAN_CH:0]   tok_chain;
    res_t               res_chain [SCAN_CH+1];
    res_t               res_cur;

    // Handshake control.
    assign s_tready = !busy_reg;
    assign start    = s_tvalid && s_tready;
    assign out_ok   = !m_tvalid_reg || m_tready;
    assign adv      = busy_reg && !flush_reg && out_ok;
    assign shift    = start || adv;
    assign scan_end = adv && tok_vec[SCAN_CH-1];

    // Row of channel cells.
    assign tok_chain[0] = start;
    assign res_chain[0] = '0;

    for (genvar g = 0; g < SCAN_CH; g++)
    begin : g_cell
        mlbc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (LED_W'(g)),
            .shift    (shift),
            .tok_in   (tok_chain[g]),
            .tok_out  (tok_chain[g+1]),
            .item     (item_reg),
            .res_in   (res_chain[g]),
            .res_out  (res_chain[g+1])
        );
        assign tok_vec[g] = tok_chain[g+1];
    end

    assign res_cur = res_chain[SCAN_CH];

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg.op           <= s_tuser;
            item_reg.target_led   <= s_tdata[2:0];
            item_reg.mode         <= s_tdata[4:3];
            item_reg.duty         <= s_tdata[12:5];
            item_reg.on_ms        <= s_tdata[28:13];
            item_reg.off_ms       <= s_tdata[44:29];
            item_reg.now_ms       <= s_tdata[76:45];
            item_reg.driver_ready <= s_tdata[77];
        end
    end

    // Sequencing, write buffer and output register. A write is held back by one
    // step so that the last one of an item can be marked when the scan ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            flush_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tlast_reg    <= 1'b0;
            held_led_reg   <= '0;
            held_level_reg <= '0;
            m_led_reg      <= '0;
            m_level_reg    <= '0;
        end
        else
        begin
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            if (adv)
            begin
                if (res_cur.emit)
                begin
                    if (held_valid_reg)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_led_reg    <= held_led_reg;
                        m_level_reg  <= held_level_reg;
                        m_tlast_reg  <= 1'b0;
                    end
                    held_valid_reg <= 1'b1;
                    held_led_reg   <= res_cur.led;
                    held_level_reg <= res_cur.level;
                end
                if (scan_end)
                begin
                    flush_reg <= 1'b1;
                end
            end
            if (flush_reg && out_ok)
            begin
                if (held_valid_reg)
                begin
                    m_tvalid_reg <= 1'b1;
                    m_led_reg    <= held_led_reg;
                    m_level_reg  <= held_level_reg;
                    m_tlast_reg  <= 1'b1;
                end
                held_valid_reg <= 1'b0;
                flush_reg      <= 1'b0;
                busy_reg       <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_level_reg, m_led_reg};
    assign m_tlast  = m_tlast_reg;

    // Checks on the scan sequencing.
    `MLBC_ASSERT_IMP(a_tok_single, 1'b1, $onehot0(tok_vec), "more than one cell holds the token")
    `MLBC_ASSERT_IMP(a_idle_empty, !busy_reg, (tok_vec == '0) && !held_valid_reg, "idle with work left")
    `MLBC_ASSERT_IMP(a_flush_no_tok, flush_reg, tok_vec == '0, "token present while flushing")
    `MLBC_ASSERT_NXT(a_flush_ends, flush_reg && out_ok, !busy_reg && !held_valid_reg, "flush did not end item")

endmodule

>>> tb/sv/tb_multi_led_blink_controller.sv
module tb_multi_led_blink_controller;
    import mlbc_pkg::*;

    // Codes that the block ignores.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int IDLE_PCT     = 27;
    localparam int RANDOM_ITEMS = 410;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    // One level write as it leaves the block.
    typedef struct packed {
        led_t       led;
        logic [7:0] level;
        logic       last;
    } led_write_t;

    // Per-channel blink state and the queue of level writes it predicts.
    class led_blink_scoreboard;
        logic [1:0]  chan_mode    [SCAN_CH];
        logic [7:0]  chan_duty    [SCAN_CH];
        logic [15:0] chan_on      [SCAN_CH];
        logic [15:0] chan_off     [SCAN_CH];
        logic [31:0] chan_stamp   [SCAN_CH];
        logic        chan_lit     [SCAN_CH];
        logic        chan_pending [SCAN_CH];
        led_write_t  pending_writes[$];
        int          mismatches;

        function new();
            for (int ch = 0; ch < SCAN_CH; ch++)
            begin
                chan_mode[ch]    = MODE_OFF;
                chan_duty[ch]    = 8'd0;
                chan_on[ch]      = 16'd0;
                chan_off[ch]     = 16'd0;
                chan_stamp[ch]   = 32'd0;
                chan_lit[ch]     = 1'b0;
                chan_pending[ch] = 1'b0;
            end
            mismatches = 0;
        endfunction

        // Update the channel state for an accepted input transfer and queue its writes.
        function void note_item(item_t it);
            led_write_t  burst[$];
            logic [31:0] span;
            logic [31:0] interval;
            int          ch;
            if (it.op == OP_TICK)
            begin
                if (!it.driver_ready)
                    return;
                for (ch = 0; ch < SCAN_CH; ch++)
                begin
                    case (chan_mode[ch])
                        MODE_OFF:
                        begin
                            burst.push_back('{led_t'(ch), LEVEL_DARK, 1'b0});
                            chan_stamp[ch] = it.now_ms;
                            chan_lit[ch]   = 1'b0;
                        end
                        MODE_ON:
                        begin
                            burst.push_back('{led_t'(ch), LEVEL_DARK - chan_duty[ch], 1'b0});
                            chan_stamp[ch] = it.now_ms;
                            chan_lit[ch]   = 1'b1;
                        end
                        MODE_BLINK:
                        begin
                            if (chan_pending[ch])
                            begin
                                // A fresh blink always starts lit.
                                chan_lit[ch]     = 1'b1;
                                chan_pending[ch] = 1'b0;
                                chan_stamp[ch]   = it.now_ms;
                                burst.push_back('{led_t'(ch), LEVEL_LIT, 1'b0});
                            end
                            else
                            begin
                                // A zero interval counts as one millisecond.
                                interval = {16'd0, chan_lit[ch] ? chan_on[ch] : chan_off[ch]};
                                if (interval == 32'd0)
                                    interval = 32'd1;
                                span = it.now_ms - chan_stamp[ch];
                                if (span >= interval)
                                begin
                                    chan_lit[ch]   = !chan_lit[ch];
                                    chan_stamp[ch] = it.now_ms;
                                    burst.push_back('{led_t'(ch),
                                        chan_lit[ch] ? LEVEL_LIT : LEVEL_DARK, 1'b0});
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (burst.size() > 0)
                    burst[burst.size() - 1].last = 1'b1;
                foreach (burst[k])
                    pending_writes.push_back(burst[k]);
                return;
            end

            // Channels beyond the scan range are ignored.
            if (int'(it.target_led) >= SCAN_CH)
                return;
            ch = int'(it.target_led);

            if (it.op == OP_SET_MODE)
            begin
                if (it.mode == MODE_BLINK)
                begin
                    chan_mode[ch]    = MODE_BLINK;
                    chan_on[ch]      = it.on_ms;
                    chan_off[ch]     = it.off_ms;
                    chan_duty[ch]    = 8'd255;
                    chan_pending[ch] = 1'b1;
                end
                else if (it.mode == MODE_OFF || it.mode == MODE_ON)
                begin
                    chan_mode[ch]    = it.mode;
                    chan_on[ch]      = 16'd0;
                    chan_off[ch]     = 16'd0;
                    chan_stamp[ch]   = it.now_ms;
                    chan_duty[ch]    = (it.mode == MODE_ON) ? 8'd255 : 8'd0;
                    chan_pending[ch] = 1'b0;
                end
            end
            else if (it.op == OP_SET_STEADY)
            begin
                chan_mode[ch]    = (it.duty == 8'd0) ? MODE_OFF : MODE_ON;
                chan_duty[ch]    = it.duty;
                chan_on[ch]      = 16'd0;
                chan_off[ch]     = 16'd0;
                chan_stamp[ch]   = it.now_ms;
                chan_pending[ch] = 1'b0;
                if (it.driver_ready)
                    pending_writes.push_back('{it.target_led, LEVEL_DARK - it.duty, 1'b1});
            end
        endfunction

        // Compare an accepted output transfer with the oldest predicted write.
        function void check_write(led_t led, logic [7:0] level, logic last);
            led_write_t want;
            if (pending_writes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected write: led %0d level %0d last %0b", led, level, last);
                return;
            end
            want = pending_writes.pop_front();
            if (led !== want.led || level !== want.level || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Write mismatch: expected led %0d level %0d last %0b, %s %0d %0d %0b",
                        want.led, want.level, want.last, "got", led, level, last);
            end
        endfunction

        function int outstanding();
            return pending_writes.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    led_blink_scoreboard sb = new();
    logic                calm = 1'b0;
    int                  quiet_cycles = 0;

    multi_led_blink_controller uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Random back-pressure on the output side, switched off during the calm stretch.
    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Check every accepted output transfer.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_write(m_tdata[2:0], m_tdata[10:3], m_tlast);
    end

    // Give up when no transfer completes on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic item_t make_item(logic [1:0] op, led_t led, logic [1:0] mode,
                                        logic [7:0] duty, logic [15:0] on_ms,
                                        logic [15:0] off_ms, logic [31:0] now_ms,
                                        logic ready);
        return '{op, led, mode, duty, on_ms, off_ms, now_ms, ready};
    endfunction

    // Offer one item after a random gap and hold it until the transfer completes.
    task automatic send_item(input item_t it);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {2'b00, it.driver_ready, it.now_ms, it.off_ms, it.on_ms,
                     it.duty, it.mode, it.target_led};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_item(it);
        @(negedge clk);
    endtask

    initial
    begin
        item_t       it;
        int          counted;
        int          r;
        logic [31:0] now_clk;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_TICK;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: steady levels, blink start and toggling, ignored codes, time wrap.
        send_item(make_item(OP_TICK, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd0, 1'b1));
        send_item(make_item(OP_TICK, 3'd7, MODE_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF, 1'b0));
        send_item(make_item(OP_SET_STEADY, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd5, 1'b1));
        send_item(make_item(OP_SET_STEADY, 3'd7, MODE_OFF, 8'hFF, 16'd0, 16'd0, 32'd5, 1'b1));
        send_item(make_item(OP_SET_STEADY, 3'd3, MODE_OFF, 8'd128, 16'd0, 16'd0, 32'd5, 1'b0));
        send_item(make_item(OP_SET_MODE, 3'd1, MODE_ON, 8'd0, 16'd0, 16'd0, 32'd8, 1'b1));
        send_item(make_item(OP_SET_MODE, 3'd2, MODE_BLINK, 8'd0, 16'd0, 16'd0, 32'd10, 1'b1));
        send_item(make_item(OP_SET_MODE, 3'd4, MODE_BLINK, 8'd0, 16'hFFFF, 16'hFFFF,
                            32'd10, 1'b1));
        send_item(make_item(OP_SET_MODE, 3'd5, MODE_UNUSED, 8'd7, 16'd3, 16'd3, 32'd10, 1'b1));
        send_item(make_item(OP_UNUSED, 3'd6, MODE_BLINK, 8'hFF, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF, 1'b1));
        send_item(make_item(OP_SET_MODE, 3'd6, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd20, 1'b1));
        send_item(make_item(OP_TICK, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd100, 1'b1));
        send_item(make_item(OP_TICK, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd100, 1'b1));
        send_item(make_item(OP_TICK, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd101, 1'b1));
        send_item(make_item(OP_TICK, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd102, 1'b1));
        send_item(make_item(OP_TICK, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0,
                            32'hFFFF_FFF0, 1'b1));
        send_item(make_item(OP_SET_MODE, 3'd5, MODE_BLINK, 8'd0, 16'd3, 16'd5, 32'd0, 1'b1));
        send_item(make_item(OP_TICK, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0,
                            32'hFFFF_FFFE, 1'b1));
        send_item(make_item(OP_TICK, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd1, 1'b1));
        send_item(make_item(OP_SET_STEADY, 3'd1, MODE_OFF, 8'd1, 16'd0, 16'd0, 32'd2, 1'b1));
        send_item(make_item(OP_SET_MODE, 3'd2, MODE_ON, 8'd0, 16'd0, 16'd0, 32'd3, 1'b1));
        send_item(make_item(OP_TICK, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd6, 1'b1));
        send_item(make_item(OP_SET_STEADY, 3'd4, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd6, 1'b0));
        send_item(make_item(OP_TICK, 3'd0, MODE_OFF, 8'd0, 16'd0, 16'd0, 32'd7, 1'b1));

        // Random part: a slowly advancing time with occasional jumps, mostly short blinks.
        counted = 0;
        now_clk = $urandom;
        while (counted < RANDOM_ITEMS)
        begin
            calm = (counted >= 180 && counted < 260);
            r = $urandom_range(99);
            if (r < 3)
                now_clk = $urandom;
            else if (r < 5)
                now_clk = 32'hFFFF_FFFF - $urandom_range(0, 8);
            else
                now_clk = now_clk + $urandom_range(0, 4);

            it = make_item(2'($urandom), 3'($urandom), 2'($urandom), 8'($urandom),
                           16'($urandom), 16'($urandom), now_clk,
                           $urandom_range(99) < 85);
            r = $urandom_range(99);
            if (r < 52)
                it.op = OP_TICK;
            else if (r < 74)
            begin
                it.op = OP_SET_MODE;
                r = $urandom_range(99);
                it.mode = (r < 60) ? MODE_BLINK : (r < 75) ? MODE_OFF :
                          (r < 90) ? MODE_ON : MODE_UNUSED;
                if ($urandom_range(99) < 85)
                begin
                    it.on_ms  = 16'($urandom_range(0, 6));
                    it.off_ms = 16'($urandom_range(0, 6));
                end
            end
            else if (r < 94)
            begin
                it.op = OP_SET_STEADY;
                if ($urandom_range(9) == 0)
                    it.duty = 8'd0;
            end
            else
                it.op = OP_UNUSED;

            send_item(it);
            counted++;
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Let the last writes drain, then allow time for any stray ones.
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> multi_led_blink_controller.f
+incdir+src
src/mlbc_pkg.sv
src/mlbc_cell.sv
src/multi_led_blink_controller.sv
tb/sv/tb_multi_led_blink_controller.sv
